/* design/utf16be_bom_to_utf8_transcoder_top_defines.svh */
// Assertion macros shared by the transcoder modules.
// Every module that uses them has i_clk and i_rst_n in scope.
`ifndef UTF16BE_BOM_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH
`define UTF16BE_BOM_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define U16U8_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("transcoder assertion failed");

// Check that a condition never holds outside reset.
`define U16U8_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("transcoder forbidden condition seen");

`else

`define U16U8_ASSERT(label, prop)
`define U16U8_NEVER(label, cond)

`endif

`endif

/* design/u16u8_pkg.sv */
package u16u8_pkg;

    // Input phases of one string
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_U16   = 2'd2;
    localparam logic [1:0] PH_PASS  = 2'd3;

    // Kind of one element of a job
    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_RAW  = 2'd1;
    localparam logic [1:0] K_CP   = 2'd2;

    localparam logic [7:0] BOM_HI = 8'hFE;
    localparam logic [7:0] BOM_LO = 8'hFF;

    // Job queue depth
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // One job: up to two elements, each a raw byte or a code point
    typedef struct packed {
        logic        last;
        logic [1:0]  a_kind;
        logic [20:0] a_val;
        logic [1:0]  b_kind;
        logic [15:0] b_val;
    } t_job;

    // Number of UTF-8 bytes of a code point, minus one
    function automatic logic [1:0] u8_lenm1(input logic [20:0] cp);
        logic [1:0] n;
        if (cp <= 21'h7F) begin
            n = 2'd0;
        end else if (cp <= 21'h7FF) begin
            n = 2'd1;
        end else if (cp <= 21'hFFFF) begin
            n = 2'd2;
        end else begin
            n = 2'd3;
        end
        return n;
    endfunction

    // Byte number idx of the UTF-8 form of cp
    function automatic logic [7:0] u8_byte(input logic [20:0] cp, input logic [1:0] lenm1,
                                           input logic [1:0] idx);
        logic [1:0] seg;
        logic [7:0] lead;
        logic [7:0] cont;
        seg = lenm1 - idx;
        case (lenm1)
            2'd0:    lead = {1'b0, cp[6:0]};
            2'd1:    lead = {3'b110, cp[10:6]};
            2'd2:    lead = {4'b1110, cp[15:12]};
            default: lead = {5'b11110, cp[20:18]};
        endcase
        case (seg)
            2'd0:    cont = {2'b10, cp[5:0]};
            2'd1:    cont = {2'b10, cp[11:6]};
            2'd2:    cont = {2'b10, cp[17:12]};
            default: cont = {2'b10, 3'b000, cp[20:18]};
        endcase
        return (idx == 2'd0) ? lead : cont;
    endfunction

endpackage

/* design/u16u8_in_if.sv */
interface u16u8_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_in;

    modport source (output valid, output in_byte, output last_in, input ready);
    modport sink (input valid, input in_byte, input last_in, output ready);
endinterface

/* design/u16u8_out_if.sv */
interface u16u8_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       no_data;
    logic       last_out;

    modport source (output valid, output out_byte, output no_data, output last_out,
                    input ready);
    modport sink (input valid, input out_byte, input no_data, input last_out,
                  output ready);
endinterface

/* design/u16u8_queue.sv */
`include "utf16be_bom_to_utf8_transcoder_top_defines.svh"

module u16u8_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u16u8_pkg::t_job   i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output u16u8_pkg::t_job   o_data
);

    u16u8_pkg::t_job r_mem [u16u8_pkg::QDEPTH];
    logic [u16u8_pkg::QAW-1:0] r_wp, r_rp;
    logic [u16u8_pkg::QAW:0]   r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == (u16u8_pkg::QAW+1)'(u16u8_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store a request at the write pointer
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `U16U8_ASSERT(a_cnt_bound, r_cnt <= (u16u8_pkg::QAW+1)'(u16u8_pkg::QDEPTH))
    `U16U8_NEVER(a_pop_empty, i_pop && !o_valid)
    `U16U8_NEVER(a_push_full, i_push && o_full)

endmodule

/* design/u16u8_front.sv */
`include "utf16be_bom_to_utf8_transcoder_top_defines.svh"

module u16u8_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    u16u8_in_if.sink         i_in,
    input  logic             i_full,
    output logic             o_push,
    output u16u8_pkg::t_job  o_job
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_first, n_first;
    logic       r_half_vld, n_half_vld;
    logic [7:0] r_half, n_half;
    logic       r_hp, n_hp;
    logic [9:0] r_hbits, n_hbits;

    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic [15:0] u;
    logic        u_high, u_low;
    u16u8_pkg::t_job job;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.in_byte;
    assign last       = i_in.last_in;
    assign u          = {r_half, b};
    assign u_high     = (u >= 16'hD800) && (u <= 16'hDBFF);
    assign u_low      = (u >= 16'hDC00) && (u <= 16'hDFFF);

    // Classify the byte into a job and the next state
    always_comb begin
        n_phase    = r_phase;
        n_first    = r_first;
        n_half_vld = r_half_vld;
        n_half     = r_half;
        n_hp       = r_hp;
        n_hbits    = r_hbits;
        job        = '0;
        job.last   = last;
        case (r_phase)
            u16u8_pkg::PH_START: begin
                if (last) begin
                    job.a_kind = u16u8_pkg::K_RAW;
                    job.a_val  = {13'd0, b};
                end else begin
                    n_first = b;
                    n_phase = u16u8_pkg::PH_FIRST;
                end
            end
            u16u8_pkg::PH_FIRST: begin
                if (r_first == u16u8_pkg::BOM_HI && b == u16u8_pkg::BOM_LO) begin
                    n_phase = u16u8_pkg::PH_U16;
                end else begin
                    job.a_kind = u16u8_pkg::K_RAW;
                    job.a_val  = {13'd0, r_first};
                    job.b_kind = u16u8_pkg::K_RAW;
                    job.b_val  = {8'd0, b};
                    n_phase    = u16u8_pkg::PH_PASS;
                end
            end
            u16u8_pkg::PH_U16: begin
                if (!r_half_vld) begin
                    n_half     = b;
                    n_half_vld = 1'b1;
                    // flush a waiting high surrogate at the end
                    if (last && r_hp) begin
                        job.a_kind = u16u8_pkg::K_CP;
                        job.a_val  = {5'd0, 6'b110110, r_hbits};
                    end
                end else begin
                    n_half_vld = 1'b0;
                    if (r_hp && u_low) begin
                        n_hp       = 1'b0;
                        job.a_kind = u16u8_pkg::K_CP;
                        job.a_val  = 21'h10000 + {1'b0, r_hbits, u[9:0]};
                    end else begin
                        if (r_hp) begin
                            job.a_kind = u16u8_pkg::K_CP;
                            job.a_val  = {5'd0, 6'b110110, r_hbits};
                        end
                        if (u_high && !last) begin
                            n_hp    = 1'b1;
                            n_hbits = u[9:0];
                        end else begin
                            n_hp       = 1'b0;
                            job.b_kind = u16u8_pkg::K_CP;
                            job.b_val  = u;
                        end
                    end
                end
            end
            default: begin
                job.a_kind = u16u8_pkg::K_RAW;
                job.a_val  = {13'd0, b};
            end
        endcase
        // return to string start after the final byte
        if (last) begin
            n_phase    = u16u8_pkg::PH_START;
            n_half_vld = 1'b0;
            n_hp       = 1'b0;
        end
    end

    assign o_job  = job;
    assign o_push = accept && (last || job.a_kind != u16u8_pkg::K_NONE
                               || job.b_kind != u16u8_pkg::K_NONE);

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= u16u8_pkg::PH_START;
            r_half_vld <= 1'b0;
            r_hp       <= 1'b0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_half_vld <= n_half_vld;
            r_hp       <= n_hp;
        end
    end

    // Hold payload bytes
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_first <= n_first;
            r_half  <= n_half;
            r_hbits <= n_hbits;
        end
    end

    `U16U8_ASSERT(a_hp_mode, r_hp |-> (r_phase == u16u8_pkg::PH_U16))
    `U16U8_ASSERT(a_half_mode, r_half_vld |-> (r_phase == u16u8_pkg::PH_U16))
    `U16U8_ASSERT(a_last_start, (accept && last) |=> (r_phase == u16u8_pkg::PH_START))

endmodule

/* design/u16u8_back.sv */
`include "utf16be_bom_to_utf8_transcoder_top_defines.svh"

module u16u8_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  u16u8_pkg::t_job  i_job,
    output logic             o_pop,
    u16u8_out_if.source      o_out
);

    logic       r_sel;
    logic [1:0] r_idx;
    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_nodata;
    logic       r_last;

    logic        a_none, b_none, cur_b;
    logic [1:0]  kind;
    logic [20:0] cp;
    logic [1:0]  lenm1;
    logic [7:0]  byte_val;
    logic        nodat, elem_end, job_end, load;

    // Pick the current element of the head request
    assign a_none   = (i_job.a_kind == u16u8_pkg::K_NONE);
    assign b_none   = (i_job.b_kind == u16u8_pkg::K_NONE);
    assign cur_b    = r_sel || a_none;
    assign kind     = cur_b ? i_job.b_kind : i_job.a_kind;
    assign cp       = cur_b ? {5'd0, i_job.b_val} : i_job.a_val;
    assign nodat    = (kind == u16u8_pkg::K_NONE);
    assign lenm1    = (kind == u16u8_pkg::K_CP) ? u16u8_pkg::u8_lenm1(cp) : 2'd0;
    assign elem_end = (r_idx == lenm1);
    assign job_end  = elem_end && (cur_b || b_none);
    assign load     = i_valid && (!r_ov || o_out.ready);
    assign o_pop    = load && job_end;

    // Encode one byte of the element
    always_comb begin
        case (kind)
            u16u8_pkg::K_RAW: byte_val = cp[7:0];
            u16u8_pkg::K_CP:  byte_val = u16u8_pkg::u8_byte(cp, lenm1, r_idx);
            default:          byte_val = 8'd0;
        endcase
    end

    // Advance through the elements and bytes of a request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
            r_idx <= 2'd0;
            r_ov  <= 1'b0;
        end else begin
            if (load) begin
                if (job_end) begin
                    r_sel <= 1'b0;
                    r_idx <= 2'd0;
                end else if (elem_end) begin
                    r_sel <= 1'b1;
                    r_idx <= 2'd0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= byte_val;
            r_nodata <= nodat;
            r_last   <= i_job.last && job_end;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_byte;
    assign o_out.no_data  = r_nodata;
    assign o_out.last_out = r_last;

    `U16U8_ASSERT(a_nodata_form, (r_ov && r_nodata) |-> (r_byte == 8'd0 && r_last))
    `U16U8_ASSERT(a_sel_head, (r_sel || r_idx != 2'd0) |-> i_valid)
    `U16U8_ASSERT(a_nodata_last, (i_valid && a_none && b_none) |-> i_job.last)

endmodule

/* design/utf16be_bom_to_utf8_transcoder_top.sv */
// Channel  Role    Handshake      Payload
// i_in     sink    valid/ready    in_byte[7:0], last_in
// o_out    source  valid/ready    out_byte[7:0], no_data, last_out
//
// One input byte is taken per cycle while the four-entry job queue has room.
// The back end sends one result byte per cycle unless o_out stalls; a request
// stays at the queue head for one to six bytes (a no-data end marker is one).
// Jobs go through the job queue, and their bytes through the output register.
// i_rst_n is synchronous and active low; it clears mode, queue and output.
// A stall on o_out fills the queue, then drops i_in.ready.
module utf16be_bom_to_utf8_transcoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u16u8_in_if.sink    i_in,
    u16u8_out_if.source o_out
);

    logic            push, full, pop, q_valid;
    u16u8_pkg::t_job push_job, head_job;

    u16u8_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    u16u8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (head_job)
    );

    u16u8_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
